[rtl/core/lhs_pkg.sv]
`default_nettype none

package lhs_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SWAP = 2'd1;
    localparam logic [1:0] OP_EMIT = 2'd2;

    // configuration register indexes
    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_DIM_COUNT    = 1'b1;

    // field widths
    localparam int BOUND_W  = 32;
    localparam int DIFF_W   = BOUND_W + 1;
    localparam int SCNT_W   = 9;
    localparam int DCNT_W   = 4;
    localparam int CFG_W    = 9;
    localparam int FDIM_W   = 3;
    localparam int FPOS_W   = 8;
    localparam int FLVL_W   = 8;

    // register reset values
    localparam logic [SCNT_W-1:0] RST_SAMPLE_COUNT = 9'd256;
    localparam logic [DCNT_W-1:0] RST_DIM_COUNT    = 4'd8;

    // parameter defaults
    localparam int DEF_MAX_DIMS    = 8;
    localparam int DEF_MAX_SAMPLES = 256;

endpackage

`default_nettype wire

[rtl/core/latin_hypercube_sampler.sv]
// Latin hypercube sampler. Keeps one level permutation per dimension in a
// single-port-write RAM plus signed Q16.16 bounds per dimension. After reset
// the RAM is swept to the identity, one entry per cycle, over MAX_DIMS times
// 2**clog2(MAX_SAMPLES) entries (2048 with the defaults), during which input
// is stalled; configuration writes are taken at any time. A load_range item
// is taken without leaving idle, and a swap does two reads and two writes
// through the RAM's one read and one write port. For an emit, per active
// dimension, the scaling unit multiplies one level bit per cycle and
// divides one quotient bit per cycle. Results leave through an output
// register, so the next dimension is computed while a result waits to be
// taken.
`default_nettype none

module latin_hypercube_sampler
    import lhs_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    // input items
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic [FDIM_W-1:0]  i_dimension,
    input  wire logic [FPOS_W-1:0]  i_position_a,
    input  wire logic [FPOS_W-1:0]  i_position_b,
    input  wire logic [BOUND_W-1:0] i_range_low,
    input  wire logic [BOUND_W-1:0] i_range_high,
    // result items
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [BOUND_W-1:0] o_point_value,
    output logic      [FDIM_W-1:0]  o_out_dimension,
    output logic      [FLVL_W-1:0]  o_level,
    output logic                    o_last
);

    localparam int LVL_W   = $clog2(MAX_SAMPLES);
    localparam int N_W     = $clog2(MAX_SAMPLES + 1);
    localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ND_W    = $clog2(MAX_DIMS + 1);
    localparam int DEPTH   = MAX_DIMS * (2 ** LVL_W);
    localparam int AW      = $clog2(DEPTH);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SW_RA    = 4'd2;
    localparam logic [3:0] S_SW_RB    = 4'd3;
    localparam logic [3:0] S_SW_WA    = 4'd4;
    localparam logic [3:0] S_SW_WB    = 4'd5;
    localparam logic [3:0] S_EM_RD    = 4'd6;
    localparam logic [3:0] S_EM_START = 4'd7;
    localparam logic [3:0] S_EM_CALC  = 4'd8;
    localparam logic [3:0] S_EM_OUT   = 4'd9;

    logic [3:0]         r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [SCNT_W-1:0]  r_sample_count;
    logic [DCNT_W-1:0]  r_dim_count;
    logic [DIM_W-1:0]   r_dim;
    logic [LVL_W-1:0]   r_pos_a;
    logic [LVL_W-1:0]   r_pos_b;
    logic [LVL_W-1:0]   r_tmp;
    logic [LVL_W-1:0]   r_lvl;
    logic [BOUND_W-1:0] r_lo_tab [0:MAX_DIMS-1];
    logic [BOUND_W-1:0] r_hi_tab [0:MAX_DIMS-1];

    logic               r_out_valid;
    logic [BOUND_W-1:0] r_out_value;
    logic [FDIM_W-1:0]  r_out_dim;
    logic [FLVL_W-1:0]  r_out_level;
    logic               r_out_last;

    logic [N_W-1:0]     eff_n;
    logic [ND_W-1:0]    eff_nd;
    logic               in_xfer;
    logic               dim_ok;
    logic               pa_ok;
    logic               pb_ok;
    logic               dim_last;
    logic               out_load;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LVL_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [LVL_W-1:0]   ram_rdata;
    logic               sc_start;
    logic               sc_done;
    logic [BOUND_W-1:0] sc_value;

    // effective counts, clamped to the supported range
    always_comb begin
        if (r_sample_count == '0) begin
            eff_n = N_W'(1);
        end else if (32'(r_sample_count) > 32'(MAX_SAMPLES)) begin
            eff_n = N_W'(MAX_SAMPLES);
        end else begin
            eff_n = N_W'(r_sample_count);
        end
        if (r_dim_count == '0) begin
            eff_nd = ND_W'(1);
        end else if (32'(r_dim_count) > 32'(MAX_DIMS)) begin
            eff_nd = ND_W'(MAX_DIMS);
        end else begin
            eff_nd = ND_W'(r_dim_count);
        end
    end

    // input checks
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign dim_ok   = (32'(i_dimension) < 32'(MAX_DIMS));
    assign pa_ok    = (32'(i_position_a) < 32'(eff_n));
    assign pb_ok    = (32'(i_position_b) < 32'(eff_n));
    assign dim_last = ((ND_W'(r_dim) + ND_W'(1)) == eff_nd);

    // level table addressing
    assign addr_a = AW'({r_dim, r_pos_a});
    assign addr_b = AW'({r_dim, r_pos_b});

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_a;
        ram_wdata = ram_rdata;
        ram_raddr = addr_a;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = r_clr_addr[LVL_W-1:0];
            end
            S_SW_RB: begin
                ram_raddr = addr_b;
            end
            S_SW_WA: begin
                ram_we = 1'b1;
            end
            S_SW_WB: begin
                ram_we    = 1'b1;
                ram_waddr = addr_b;
                ram_wdata = r_tmp;
            end
            default: begin
            end
        endcase
    end

    lhs_ram #(
        .WIDTH (LVL_W),
        .DEPTH (DEPTH)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // per-dimension scaling unit
    assign sc_start = (r_state == S_EM_START);

    lhs_scaler #(
        .LVL_W (LVL_W),
        .N_W   (N_W)
    ) u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sc_start),
        .i_lo    (r_lo_tab[r_dim]),
        .i_hi    (r_hi_tab[r_dim]),
        .i_lvl   (ram_rdata),
        .i_n     (eff_n),
        .o_done  (sc_done),
        .o_value (sc_value)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= RST_SAMPLE_COUNT;
            r_dim_count    <= RST_DIM_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[SCNT_W-1:0];
                CFG_DIM_COUNT:    r_dim_count    <= i_cfg_data[DCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // bound tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_lo_tab[d] <= '0;
                r_hi_tab[d] <= '0;
            end
        end else if (in_xfer && (i_operation == OP_LOAD) && dim_ok) begin
            r_lo_tab[DIM_W'(i_dimension)] <= i_range_low;
            r_hi_tab[DIM_W'(i_dimension)] <= i_range_high;
        end
    end

    // sequencer: clearing sweep, swaps and emits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pos_a <= LVL_W'(i_position_a);
                        r_pos_b <= LVL_W'(i_position_b);
                        priority if ((i_operation == OP_SWAP) && dim_ok && pa_ok && pb_ok) begin
                            r_dim   <= DIM_W'(i_dimension);
                            r_state <= S_SW_RA;
                        end else if ((i_operation == OP_EMIT) && pa_ok) begin
                            r_dim   <= '0;
                            r_state <= S_EM_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SW_RA: begin
                    r_state <= S_SW_RB;
                end
                S_SW_RB: begin
                    r_tmp   <= ram_rdata;
                    r_state <= S_SW_WA;
                end
                S_SW_WA: begin
                    r_state <= S_SW_WB;
                end
                S_SW_WB: begin
                    r_state <= S_IDLE;
                end
                S_EM_RD: begin
                    r_state <= S_EM_START;
                end
                S_EM_START: begin
                    r_lvl   <= ram_rdata;
                    r_state <= S_EM_CALC;
                end
                S_EM_CALC: begin
                    if (sc_done) begin
                        r_state <= S_EM_OUT;
                    end
                end
                S_EM_OUT: begin
                    if (out_load) begin
                        if (dim_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_dim   <= r_dim + DIM_W'(1);
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // output register
    assign out_load = (r_state == S_EM_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= sc_value;
            r_out_dim   <= FDIM_W'(r_dim);
            r_out_level <= FLVL_W'(r_lvl);
            r_out_last  <= dim_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_point_value   = r_out_value;
    assign o_out_dimension = r_out_dim;
    assign o_level         = r_out_level;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

[rtl/core/lhs_ram.sv]
`default_nettype none

module lhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/lhs_scaler.sv]
`default_nettype none

module lhs_scaler
    import lhs_pkg::*;
#(
    parameter int LVL_W = 8,
    parameter int N_W   = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [BOUND_W-1:0] i_lo,
    input  wire logic [BOUND_W-1:0] i_hi,
    input  wire logic [LVL_W-1:0]   i_lvl,
    input  wire logic [N_W-1:0]     i_n,
    output logic                    o_done,
    output logic      [BOUND_W-1:0] o_value
);

    localparam int PROD_W = DIFF_W + LVL_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [2:0] SC_IDLE = 3'd0;
    localparam logic [2:0] SC_MUL  = 3'd1;
    localparam logic [2:0] SC_DIV  = 3'd2;
    localparam logic [2:0] SC_NEG  = 3'd3;
    localparam logic [2:0] SC_SUM  = 3'd4;

    logic [2:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [BOUND_W-1:0] r_lo;
    logic               r_neg;
    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_mcand;
    logic [LVL_W-1:0]   r_mplier;
    logic [N_W-1:0]     r_n;
    logic [N_W-1:0]     r_rem;
    logic [PROD_W:0]    r_q;
    logic [BOUND_W-1:0] r_value;

    logic [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]    mag;
    logic [N_W:0]         trial;
    logic                 ge;
    logic [PROD_W:0]      q_inc;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-BOUND_W:0] sum_top;
    logic [BOUND_W-1:0]   sat;

    // range width and its magnitude
    assign diff = {i_hi[BOUND_W-1], i_hi} - {i_lo[BOUND_W-1], i_lo};
    assign mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    // restoring division step, one quotient bit per cycle
    assign trial = {r_rem, r_acc[PROD_W-1]};
    assign ge    = (trial >= {1'b0, r_n});

    // floor rounding: negative quotients round away from zero on a remainder
    assign q_inc = {1'b0, r_acc} + (PROD_W + 1)'(r_rem != '0);

    // final sum with saturation to 32 bits
    assign sum     = {{(SUM_W - BOUND_W){r_lo[BOUND_W-1]}}, r_lo} + {r_q[PROD_W], r_q};
    assign sum_top = sum[SUM_W-1:BOUND_W-1];
    assign sat     = ((&sum_top) || !(|sum_top)) ? sum[BOUND_W-1:0] :
                     (sum[SUM_W-1] ? {1'b1, {(BOUND_W - 1){1'b0}}}
                                   : {1'b0, {(BOUND_W - 1){1'b1}}});

    // shift-add multiply, shift-subtract divide, then sign and saturated sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == SC_SUM);
            unique case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_lo     <= i_lo;
                        r_neg    <= diff[DIFF_W-1];
                        r_acc    <= '0;
                        r_mcand  <= PROD_W'(mag);
                        r_mplier <= i_lvl;
                        r_n      <= i_n;
                        r_rem    <= '0;
                        r_cnt    <= CNT_W'(LVL_W - 1);
                        r_state  <= SC_MUL;
                    end
                end
                SC_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(PROD_W - 1);
                        r_state <= SC_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                SC_DIV: begin
                    r_rem <= ge ? N_W'(trial - {1'b0, r_n}) : N_W'(trial);
                    r_acc <= {r_acc[PROD_W-2:0], ge};
                    if (r_cnt == '0) begin
                        r_state <= SC_NEG;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                SC_NEG: begin
                    r_q     <= r_neg ? (~q_inc + (PROD_W + 1)'(1)) : {1'b0, r_acc};
                    r_state <= SC_SUM;
                end
                SC_SUM: begin
                    r_value <= sat;
                    r_state <= SC_IDLE;
                end
                default: begin
                    r_state <= SC_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

`default_nettype wire

[verif/latin_hypercube_sampler_test.sv]
`default_nettype none

module latin_hypercube_sampler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lhs_pkg::*;

    localparam int NUM_DIMS      = DEF_MAX_DIMS;
    localparam int NUM_SAMPLES   = DEF_MAX_SAMPLES;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_ITEMS   = 90;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint POINT_MAX = 64'sh7FFF_FFFF;
    localparam longint POINT_MIN = -64'sh8000_0000;

    // one coordinate of an emitted sample point
    typedef struct {
        logic [BOUND_W-1:0] value;
        logic [FDIM_W-1:0]  dim;
        logic [FLVL_W-1:0]  level;
        logic               last;
    } coord_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          in_op = OP_LOAD;
    logic [FDIM_W-1:0]   in_dim = '0;
    logic [FPOS_W-1:0]   in_pos_a = '0;
    logic [FPOS_W-1:0]   in_pos_b = '0;
    logic [BOUND_W-1:0]  in_lo = '0;
    logic [BOUND_W-1:0]  in_hi = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [BOUND_W-1:0]  point_value;
    logic [FDIM_W-1:0]   out_dim;
    logic [FLVL_W-1:0]   out_level;
    logic                out_last;

    // predicted block state
    logic [FLVL_W-1:0]         level_perm [NUM_DIMS][NUM_SAMPLES];
    logic signed [BOUND_W-1:0] lo_bound [NUM_DIMS];
    logic signed [BOUND_W-1:0] hi_bound [NUM_DIMS];
    logic [SCNT_W-1:0]         samples_reg = RST_SAMPLE_COUNT;
    logic [DCNT_W-1:0]         dims_reg = RST_DIM_COUNT;
    coord_t                    pending_coords [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    latin_hypercube_sampler dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_operation     (in_op),
        .i_dimension     (in_dim),
        .i_position_a    (in_pos_a),
        .i_position_b    (in_pos_b),
        .i_range_low     (in_lo),
        .i_range_high    (in_hi),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_point_value   (point_value),
        .o_out_dimension (out_dim),
        .o_level         (out_level),
        .o_last          (out_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: long hold-off on request, random stalls otherwise
    always @(posedge clk) begin
        if (hold_requests != holds_started) begin
            holds_started = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // compare each result transfer with the oldest predicted coordinate
    always @(posedge clk) begin : check_coords
        coord_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (pending_coords.size() == 0) begin
                $error("unexpected coordinate: value %h dim %0d level %0d",
                       point_value, out_dim, out_level);
                mismatches++;
            end else begin
                want = pending_coords.pop_front();
                if (point_value !== want.value) begin
                    $error("point_value: expected %h, got %h", want.value, point_value);
                    mismatches++;
                end
                if (out_dim !== want.dim) begin
                    $error("out_dimension: expected %0d, got %0d", want.dim, out_dim);
                    mismatches++;
                end
                if (out_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, out_level);
                    mismatches++;
                end
                if (out_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_last);
                    mismatches++;
                end
            end
        end
    end

    function automatic int active_samples();
        if (samples_reg == 0) return 1;
        if (samples_reg > NUM_SAMPLES) return NUM_SAMPLES;
        return int'(samples_reg);
    endfunction

    function automatic int active_dims();
        if (dims_reg == 0) return 1;
        if (dims_reg > NUM_DIMS) return NUM_DIMS;
        return int'(dims_reg);
    endfunction

    // low + floor(level * (high - low) / n), saturated to 32 bits
    function automatic logic [BOUND_W-1:0] scale_level(input logic signed [BOUND_W-1:0] lo,
                                                       input logic signed [BOUND_W-1:0] hi,
                                                       input int lvl, input int n);
        longint span, prod, quot, total;
        span = longint'(hi) - longint'(lo);
        prod = longint'(lvl) * span;
        if (prod >= 0)
            quot = prod / n;
        else
            quot = -((-prod + n - 1) / n);
        total = longint'(lo) + quot;
        if (total > POINT_MAX) return 32'h7FFF_FFFF;
        if (total < POINT_MIN) return 32'h8000_0000;
        return total[BOUND_W-1:0];
    endfunction

    // bound values weighted toward the extremes and small fixed point numbers
    function automatic logic [BOUND_W-1:0] random_bound();
        logic [BOUND_W-1:0] edges [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        case ($urandom_range(3, 0))
            0: return edges[$urandom_range(3, 0)];
            1: return {{8{1'($urandom_range(1, 0))}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // offer one item, wait for its transfer, then advance the predictor
    task automatic send_item(input logic [1:0] op, input logic [FDIM_W-1:0] dim,
                             input logic [FPOS_W-1:0] pa, input logic [FPOS_W-1:0] pb,
                             input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
        int n;
        int nd;
        logic [FLVL_W-1:0] held;
        coord_t c;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_dim   <= dim;
        in_pos_a <= pa;
        in_pos_b <= pb;
        in_lo    <= lo;
        in_hi    <= hi;
        do @(posedge clk); while (in_stall !== 1'b0);
        n = active_samples();
        case (op)
            OP_LOAD: begin
                lo_bound[dim] = lo;
                hi_bound[dim] = hi;
            end
            OP_SWAP: begin
                if (pa < n && pb < n) begin
                    held = level_perm[dim][pa];
                    level_perm[dim][pa] = level_perm[dim][pb];
                    level_perm[dim][pb] = held;
                end
            end
            OP_EMIT: begin
                if (pa < n) begin
                    nd = active_dims();
                    for (int d = 0; d < nd; d++) begin
                        c.level = level_perm[d][pa];
                        c.value = scale_level(lo_bound[d], hi_bound[d], int'(c.level), n);
                        c.dim   = FDIM_W'(d);
                        c.last  = (d == nd - 1);
                        pending_coords.push_back(c);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic load_range(input logic [FDIM_W-1:0] dim, input logic [BOUND_W-1:0] lo,
                              input logic [BOUND_W-1:0] hi);
        send_item(OP_LOAD, dim, FPOS_W'($urandom), FPOS_W'($urandom), lo, hi);
    endtask

    task automatic swap_levels(input logic [FDIM_W-1:0] dim, input logic [FPOS_W-1:0] pa,
                               input logic [FPOS_W-1:0] pb);
        send_item(OP_SWAP, dim, pa, pb, $urandom, $urandom);
    endtask

    task automatic emit_point(input logic [FPOS_W-1:0] index);
        send_item(OP_EMIT, FDIM_W'($urandom), index, FPOS_W'($urandom), $urandom, $urandom);
    endtask

    // stop offering, wait out every predicted coordinate and the tail latency
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_coords.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_SAMPLE_COUNT)
            samples_reg = data[SCNT_W-1:0];
        else
            dims_reg = data[DCNT_W-1:0];
    endtask

    // mostly well-formed traffic, some out of range positions and unused codes
    task automatic random_item();
        int n;
        int pick;
        n = active_samples();
        pick = $urandom_range(99, 0);
        if (pick < 12)
            load_range(FDIM_W'($urandom), random_bound(), random_bound());
        else if (pick < 42)
            swap_levels(FDIM_W'($urandom), FPOS_W'($urandom_range(n - 1, 0)),
                        FPOS_W'($urandom_range(n - 1, 0)));
        else if (pick < 88)
            emit_point(FPOS_W'($urandom_range(n - 1, 0)));
        else if (pick < 96)
            send_item($urandom_range(1, 0) ? OP_SWAP : OP_EMIT, FDIM_W'($urandom),
                      FPOS_W'($urandom), FPOS_W'($urandom), $urandom, $urandom);
        else
            send_item(OP_UNUSED, FDIM_W'($urandom), FPOS_W'($urandom), FPOS_W'($urandom),
                      $urandom, $urandom);
    endtask

    // zero bounds and identity permutations straight out of reset
    task automatic test_identity_after_reset();
        emit_point(8'd0);
        emit_point(8'd255);
    endtask

    // full, reversed, unit and a small span below zero
    task automatic test_scaling_extremes();
        load_range(3'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        load_range(3'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        load_range(3'd2, 32'h0000_0000, 32'h0001_0000);
        load_range(3'd7, 32'hFFFF_FFFD, 32'h0000_0000);
        emit_point(8'd1);
        emit_point(8'd255);
        emit_point(8'd128);
    endtask

    // swaps at both ends, a swap of a position with itself
    task automatic test_swaps();
        swap_levels(3'd0, 8'd0, 8'd255);
        swap_levels(3'd7, 8'd255, 8'd255);
        swap_levels(3'd3, 8'd0, 8'd200);
        emit_point(8'd0);
        emit_point(8'd255);
        emit_point(8'd200);
    endtask

    // levels above a lowered sample count, ignored swaps, emits and op code
    task automatic test_saturation_and_ignored();
        drain_results();
        write_reg(CFG_SAMPLE_COUNT, 9'd4);
        load_range(3'd3, 32'h7FFF_FFFF, 32'h8000_0000);
        swap_levels(3'd0, 8'd5, 8'd1);
        swap_levels(3'd0, 8'd1, 8'd3);
        send_item(OP_UNUSED, 3'd2, 8'd0, 8'd1, $urandom, $urandom);
        emit_point(8'd4);
        emit_point(8'd0);
    endtask

    // register values below and above the usable range
    task automatic test_register_clamping();
        drain_results();
        write_reg(CFG_SAMPLE_COUNT, 9'd0);
        write_reg(CFG_DIM_COUNT, 9'd0);
        emit_point(8'd0);
        emit_point(8'd1);
        drain_results();
        write_reg(CFG_SAMPLE_COUNT, 9'h1FF);
        write_reg(CFG_DIM_COUNT, {5'($urandom), 4'hF});
        emit_point(8'd255);
    endtask

    // receiver holds off while emits keep coming, then the sender waits it out
    task automatic test_backpressure();
        drain_results();
        write_reg(CFG_SAMPLE_COUNT, 9'd256);
        write_reg(CFG_DIM_COUNT, 9'd8);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        repeat (10) begin
            if ($urandom_range(3, 0) == 0)
                swap_levels(FDIM_W'($urandom), FPOS_W'($urandom), FPOS_W'($urandom));
            else
                emit_point(FPOS_W'($urandom));
        end
        drain_results();
    endtask

    // random traffic under each idle and stall mix with its own settings
    task automatic test_random_phases();
        int idle_mix [4] = '{0, 46, 0, 24};
        int stall_mix [4] = '{0, 0, 46, 24};
        int sample_mix [4] = '{256, 16, 5, 256};
        int dim_mix [4] = '{8, 3, 8, 5};
        for (int p = 0; p < 4; p++) begin
            drain_results();
            write_reg(CFG_SAMPLE_COUNT, CFG_W'(sample_mix[p]));
            write_reg(CFG_DIM_COUNT, CFG_W'(dim_mix[p]));
            send_idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            repeat (PHASE_ITEMS) random_item();
        end
    endtask

    initial begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            for (int j = 0; j < NUM_SAMPLES; j++)
                level_perm[d][j] = FLVL_W'(j);
            lo_bound[d] = '0;
            hi_bound[d] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_identity_after_reset();
        test_scaling_extremes();
        test_swaps();
        test_saturation_and_ignored();
        test_register_clamping();
        test_backpressure();
        test_random_phases();

        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
